// ----- rtl/ncos_pkg.sv -----
`default_nettype none

package ncos_pkg;

    localparam int PHASE_BITS  = 32;
    localparam int SAMPLE_BITS = 16;
    localparam int FRAC_BITS   = PHASE_BITS - 2;

    // Quarter-cycle fraction is carried in unsigned Q30, 0 to 2^30 inclusive.
    localparam int Z_BITS = 31;

    localparam logic [Z_BITS-1:0] Q30_ONE = Z_BITS'(64'd1 << 30);
    localparam logic [63:0]       Q30_HALF = 64'd1 << 29;

    localparam logic [31:0] AMPLITUDE = 32'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);

    // Odd polynomial for sin(pi/2 * z), Q30 coefficients.
    localparam logic [31:0] COEF_C1 = 32'd1686629713;
    localparam logic [31:0] COEF_C3 = 32'd693598668;
    localparam logic [31:0] COEF_C5 = 32'd85569306;
    localparam logic [31:0] COEF_C7 = 32'd5026995;
    localparam logic [31:0] COEF_C9 = 32'd172272;

    localparam logic OP_TICK = 1'b0;
    localparam logic OP_LOAD = 1'b1;

    typedef struct packed {
        logic                  op;
        logic [PHASE_BITS-1:0] phase_value;
    } t_in_item;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic        [PHASE_BITS-1:0]  next_phase;
    } t_out_item;

    // One sine job as the front hands it to the back.
    typedef struct packed {
        logic                  negate;
        logic [Z_BITS-1:0]     z;
        logic [PHASE_BITS-1:0] next_phase;
    } t_job;

    typedef struct packed {
        logic valid;
        logic full;
    } t_q_status;

endpackage

`default_nettype wire

// ----- rtl/phase_continuous_sine_oscillator_top.sv -----
// Sine oscillator built on a phase accumulator. A tick beat returns the sine of
// the current phase as a signed sample scaled to 2^(SAMPLE_BITS-1)-1 together
// with the phase after it advances by phase_step; a load beat sets the phase
// and returns nothing. The front takes one beat per cycle while the queue is
// not full, updates the phase, and queues each tick in a two-entry queue. The
// back walks the polynomial chain one product at a time on the shared 32x32
// multiplier and takes the next queued tick as it finishes the last; loads
// are handled in the front alone. Write phase_step only while no tick is in
// flight.
`default_nettype none

module phase_continuous_sine_oscillator_top (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_cfg_we,
    input  wire  [ncos_pkg::PHASE_BITS-1:0] i_cfg_wdata,
    input  wire                            i_in_valid,
    output logic                           o_in_stall,
    input  ncos_pkg::t_in_item             i_in,
    output logic                           o_out_valid,
    input  wire                            i_out_stall,
    output ncos_pkg::t_out_item            o_out
);
    import ncos_pkg::*;

    t_q_status q_status;
    t_job      push_job;
    t_job      head_job;
    logic      push;
    logic      pop;

    ncos_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .i_in        (i_in),
        .i_q_status  (q_status),
        .o_in_stall  (o_in_stall),
        .o_push      (push),
        .o_job       (push_job)
    );

    ncos_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_job    (push_job),
        .i_pop    (pop),
        .o_status (q_status),
        .o_job    (head_job)
    );

    ncos_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_status  (q_status),
        .i_job       (head_job),
        .o_pop       (pop),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out       (o_out)
    );

endmodule

`default_nettype wire

// ----- rtl/ncos_front.sv -----
`default_nettype none

module ncos_front (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_cfg_we,
    input  wire  [ncos_pkg::PHASE_BITS-1:0] i_cfg_wdata,
    input  wire                            i_in_valid,
    input  ncos_pkg::t_in_item             i_in,
    input  ncos_pkg::t_q_status            i_q_status,
    output logic                           o_in_stall,
    output logic                           o_push,
    output ncos_pkg::t_job                 o_job
);
    import ncos_pkg::*;

    logic [PHASE_BITS-1:0]   r_phase_step;
    logic [PHASE_BITS-1:0]   r_phase;
    logic [PHASE_BITS-1:0]   n_phase;
    logic                    accept;
    logic [1:0]              quadrant;
    logic [FRAC_BITS+29:0]   frac_ext;
    logic [29:0]             z_frac;

    assign o_in_stall = i_q_status.full;
    assign accept     = i_in_valid && !i_q_status.full;
    assign o_push     = accept && (i_in.op == OP_TICK);

    // Aligning the fraction's top end to Q30 covers both narrow and wide phases.
    assign quadrant = r_phase[PHASE_BITS-1 -: 2];
    assign frac_ext = {r_phase[FRAC_BITS-1:0], 30'd0};
    assign z_frac   = frac_ext[FRAC_BITS+29 -: 30];

    always_comb begin
        o_job.negate     = quadrant[1];
        o_job.z          = quadrant[0] ? Q30_ONE - {1'b0, z_frac} : {1'b0, z_frac};
        o_job.next_phase = PHASE_BITS'(r_phase + r_phase_step);
    end

    always_comb begin
        n_phase = r_phase;
        if (accept) begin
            if (i_in.op == OP_LOAD) begin
                n_phase = i_in.phase_value;
            end else begin
                n_phase = o_job.next_phase;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_step <= '0;
            r_phase      <= '0;
        end else begin
            if (i_cfg_we) begin
                r_phase_step <= i_cfg_wdata;
            end
            r_phase <= n_phase;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/ncos_queue.sv -----
`default_nettype none

module ncos_queue (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_push,
    input  ncos_pkg::t_job       i_job,
    input  wire                  i_pop,
    output ncos_pkg::t_q_status  o_status,
    output ncos_pkg::t_job       o_job
);
    import ncos_pkg::*;

    t_job       r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       do_push;
    logic       do_pop;

    assign o_status.valid = (r_count != 2'd0);
    assign o_status.full  = (r_count == 2'd2);
    assign o_job          = r_mem[r_rd_ptr];

    assign do_push = i_push && !o_status.full;
    assign do_pop  = i_pop && o_status.valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 2'd1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/ncos_back.sv -----
`default_nettype none

module ncos_back (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  ncos_pkg::t_q_status  i_q_status,
    input  ncos_pkg::t_job       i_job,
    output logic                 o_pop,
    input  wire                  i_out_stall,
    output logic                 o_out_valid,
    output ncos_pkg::t_out_item  o_out
);
    import ncos_pkg::*;

    localparam logic [2:0] ST_SQ    = 3'd0;
    localparam logic [2:0] ST_C7    = 3'd1;
    localparam logic [2:0] ST_C5    = 3'd2;
    localparam logic [2:0] ST_C3    = 3'd3;
    localparam logic [2:0] ST_C1    = 3'd4;
    localparam logic [2:0] ST_Y     = 3'd5;
    localparam logic [2:0] ST_SCALE = 3'd6;

    logic                    r_busy;
    logic [2:0]              r_step;
    logic                    r_negate;
    logic [Z_BITS-1:0]       r_z;
    logic [Z_BITS-1:0]       r_z2;
    logic [31:0]             r_p;
    logic [PHASE_BITS-1:0]   r_next_phase;
    logic                    r_out_valid;
    t_out_item               r_out;

    logic [31:0]             mul_a;
    logic [31:0]             mul_b;
    logic [63:0]             prod;
    logic [31:0]             prod_q30;
    logic [31:0]             coef;
    logic [63:0]             rounded;
    logic [33:0]             mag_wide;
    logic [SAMPLE_BITS-1:0]  mag;
    logic [SAMPLE_BITS-1:0]  sample;
    logic                    out_free;
    logic                    advance;
    logic                    finish;

    assign out_free = !r_out_valid || !i_out_stall;
    assign advance  = r_busy && ((r_step != ST_SCALE) || out_free);
    assign finish   = r_busy && (r_step == ST_SCALE) && out_free;
    assign o_pop    = i_q_status.valid && (!r_busy || finish);

    // One shared multiplier walks the Horner chain, one product per cycle unless a held output stalls the scaling step.
    always_comb begin
        mul_a = r_p;
        mul_b = 32'(r_z2);
        coef  = COEF_C1;
        unique case (r_step)
            ST_SQ: begin
                mul_a = 32'(r_z);
                mul_b = 32'(r_z);
            end
            ST_C7: begin
                mul_a = COEF_C9;
                coef  = COEF_C7;
            end
            ST_C5: coef = COEF_C5;
            ST_C3: coef = COEF_C3;
            ST_C1: coef = COEF_C1;
            ST_Y:  mul_b = 32'(r_z);
            ST_SCALE: mul_b = AMPLITUDE;
            default: begin
                mul_a = r_p;
                mul_b = 32'(r_z2);
            end
        endcase
    end

    assign prod     = 64'(mul_a) * 64'(mul_b);
    assign prod_q30 = prod[61:30];
    assign rounded  = prod + Q30_HALF;
    assign mag_wide = rounded[63:30];

    always_comb begin
        if (mag_wide > 34'(AMPLITUDE)) begin
            mag = SAMPLE_BITS'(AMPLITUDE);
        end else begin
            mag = mag_wide[SAMPLE_BITS-1:0];
        end
        sample = r_negate ? SAMPLE_BITS'(-mag) : mag;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_step      <= ST_SQ;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_busy <= 1'b1;
                r_step <= ST_SQ;
            end else if (finish) begin
                r_busy <= 1'b0;
            end else if (advance) begin
                r_step <= r_step + 3'd1;
            end

            if (finish) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_negate     <= i_job.negate;
            r_z          <= i_job.z;
            r_next_phase <= i_job.next_phase;
        end
        if (advance) begin
            unique case (r_step)
                ST_SQ: r_z2 <= prod_q30[Z_BITS-1:0];
                ST_C7, ST_C5, ST_C3, ST_C1: r_p <= coef - prod_q30;
                ST_Y:  r_p <= prod_q30;
                ST_SCALE: begin
                    r_out.sample     <= sample;
                    r_out.next_phase <= r_next_phase;
                end
                default: r_p <= r_p;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

`default_nettype wire

// ----- rtl/ncos_checker.sv -----
`default_nettype none

module ncos_checker (
    input wire                            i_clk,
    input wire                            i_rst_n,
    input wire                            o_out_valid,
    input wire                            i_out_stall,
    input ncos_pkg::t_out_item            o_out
);
    import ncos_pkg::*;

    localparam logic [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    // A result held back by the consumer stays put.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out))
        else $error("result changed while stalled");

    // Saturation keeps the sample off the most negative code.
    a_sample_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out.sample != SAMPLE_MIN)
        else $error("sample outside full-scale range");

    // Reset leaves no result behind.
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // No result beat appears at the output right as reset is released.
    a_no_early_out: assert property (@(posedge i_clk)
        !i_rst_n ##1 i_rst_n |=> !o_out_valid)
        else $error("result appeared too soon after reset");

endmodule

bind phase_continuous_sine_oscillator_top ncos_checker u_ncos_checker (.*);

`default_nettype wire

// ----- sim/ncos_sample_checker.sv -----
`default_nettype none

module ncos_sample_checker (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_cfg_we,
    input  wire  [ncos_pkg::PHASE_BITS-1:0] i_cfg_wdata,
    input  wire                             i_in_valid,
    input  wire                             i_in_stall,
    input  ncos_pkg::t_in_item              i_in,
    input  wire                             i_out_valid,
    input  wire                             i_out_stall,
    input  ncos_pkg::t_out_item             i_out,
    output int                              o_mismatches,
    output int                              o_outstanding
);

    timeunit 1ns;
    timeprecision 1ps;

    import ncos_pkg::*;

    localparam int MAX_REPORTS = 10;

    t_out_item             expected_samples[$];
    logic [PHASE_BITS-1:0] osc_phase;
    logic [PHASE_BITS-1:0] osc_step;
    int                    mismatch_count = 0;

    // Sine of a phase word: quadrant from the top two bits, quarter-wave odd
    // polynomial in Q30 with every product truncated, then scaled and clipped.
    function automatic logic [SAMPLE_BITS-1:0] predict_sine(
        input logic [PHASE_BITS-1:0] phase
    );
        logic [1:0]  quadrant;
        logic [63:0] z;
        logic [63:0] z_sq;
        logic [63:0] poly;
        logic [63:0] mag;
        quadrant = phase[PHASE_BITS-1 -: 2];
        z = 64'(phase[FRAC_BITS-1:0]);
        if (PHASE_BITS >= 32) begin
            z = z >> (PHASE_BITS >= 32 ? PHASE_BITS - 32 : 0);
        end else begin
            z = z << (PHASE_BITS < 32 ? 32 - PHASE_BITS : 0);
        end
        if (quadrant[0]) begin
            z = (64'd1 << 30) - z;
        end
        z_sq = (z * z) >> 30;
        poly = 64'(COEF_C9);
        poly = 64'(COEF_C7) - ((poly * z_sq) >> 30);
        poly = 64'(COEF_C5) - ((poly * z_sq) >> 30);
        poly = 64'(COEF_C3) - ((poly * z_sq) >> 30);
        poly = 64'(COEF_C1) - ((poly * z_sq) >> 30);
        poly = (poly * z) >> 30;
        mag = (poly * 64'(AMPLITUDE) + Q30_HALF) >> 30;
        // The polynomial overshoots one slightly near the peaks.
        if (mag > 64'(AMPLITUDE)) begin
            mag = 64'(AMPLITUDE);
        end
        if (quadrant[1]) begin
            mag = 64'd0 - mag;
        end
        return mag[SAMPLE_BITS-1:0];
    endfunction

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            expected_samples.delete();
            osc_phase = '0;
            osc_step  = '0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_samples.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS) begin
                        $display("%0t: unexpected result beat: sample %0d next_phase %08h",
                                 $realtime, i_out.sample, i_out.next_phase);
                    end
                end else begin
                    want = expected_samples.pop_front();
                    if (i_out.sample !== want.sample
                            || i_out.next_phase !== want.next_phase) begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_REPORTS) begin
                            $display("%0t: result mismatch: sample exp %0d got %0d, %s",
                                     $realtime, want.sample, i_out.sample,
                                     $sformatf("next_phase exp %08h got %08h",
                                               want.next_phase, i_out.next_phase));
                        end
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                if (i_in.op == OP_LOAD) begin
                    osc_phase = i_in.phase_value;
                end else begin
                    want.sample     = predict_sine(osc_phase);
                    osc_phase       = osc_phase + osc_step;
                    want.next_phase = osc_phase;
                    expected_samples.push_back(want);
                end
            end
            // A step written at this edge applies from the next beat on.
            if (i_cfg_we) begin
                osc_step = i_cfg_wdata;
            end
        end
        o_mismatches  = mismatch_count;
        o_outstanding = expected_samples.size();
    end

endmodule

`default_nettype wire

// ----- sim/phase_continuous_sine_oscillator_top_test.sv -----
`default_nettype none

module phase_continuous_sine_oscillator_top_test;

    timeunit 1ns;
    timeprecision 1ps;

    import ncos_pkg::*;

    localparam int ITEMS_PER_PHASE = 92;
    localparam int NUM_PHASES      = 6;
    localparam int MAX_GAP         = 14;
    localparam int HOLD_CYCLES     = 120;
    localparam int SETTLE_CYCLES   = 12;
    localparam int DRAIN_CYCLES    = 20;
    localparam int WATCHDOG_LIMIT  = 1000;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [PHASE_BITS-1:0] cfg_wdata;
    logic                  in_valid;
    logic                  in_stall;
    t_in_item              in_beat;
    logic                  out_valid;
    logic                  out_stall;
    t_out_item             out_beat;

    int   mismatches;
    int   outstanding;
    int   idle_cycles;
    logic sender_quiet   = 1'b0;
    logic receiver_quiet = 1'b0;
    logic hold_request   = 1'b0;

    phase_continuous_sine_oscillator_top DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in        (in_beat),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out       (out_beat)
    );

    ncos_sample_checker checker_inst (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_wdata   (cfg_wdata),
        .i_in_valid    (in_valid),
        .i_in_stall    (in_stall),
        .i_in          (in_beat),
        .i_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .i_out         (out_beat),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Offers one beat after a random gap (none when the sender is quiet) and returns at the edge that takes it.
    task automatic send_beat(input logic op, input logic [PHASE_BITS-1:0] phase);
        int gap;
        gap = sender_quiet ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid            <= 1'b1;
        in_beat.op          <= op;
        in_beat.phase_value <= phase;
        do @(posedge i_clk); while (in_stall);
    endtask

    // The step may only change with no tick in flight, and a load can still be
    // in the front after the last result, so wait out the pipeline as well.
    task automatic write_step(input logic [PHASE_BITS-1:0] step);
        in_valid <= 1'b0;
        @(posedge i_clk);
        wait (outstanding == 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= step;
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic load_and_tick(input logic [PHASE_BITS-1:0] phase);
        send_beat(OP_LOAD, phase);
        send_beat(OP_TICK, $urandom);
    endtask

    initial begin
        logic [PHASE_BITS-1:0] step;
        logic [PHASE_BITS-1:0] phase;
        logic                  op;
        i_rst_n   = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        in_valid  = 1'b0;
        in_beat   = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Zero step: the phase stays at zero and the same sample repeats.
        write_step('0);
        send_beat(OP_TICK, '1);
        send_beat(OP_TICK, '0);
        // Peaks, zero crossings, the edges of the quadrants and a mid-quadrant phase.
        load_and_tick(32'h4000_0000);
        load_and_tick(32'h8000_0000);
        load_and_tick(32'hC000_0000);
        load_and_tick(32'hFFFF_FFFF);
        load_and_tick(32'h3FFF_FFFF);
        load_and_tick(32'h4000_0001);
        load_and_tick(32'h2000_0000);
        // Largest step moves the phase back by one code on every tick.
        write_step('1);
        send_beat(OP_LOAD, '0);
        send_beat(OP_TICK, $urandom);
        send_beat(OP_TICK, $urandom);
        write_step(32'h4000_0000);
        repeat (4) send_beat(OP_TICK, $urandom);

        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                1:       step = PHASE_BITS'($urandom_range(1, 1 << 20));
                2:       step = '1;
                3:       step = '0;
                4:       step = 32'h8000_0000;
                default: step = $urandom;
            endcase
            write_step(step);
            sender_quiet   = (p == 2) || (p == 3);
            receiver_quiet = (p == 3);
            // Receiver holds off while the sender keeps offering beats.
            if (p == 2) begin
                hold_request = 1'b1;
            end
            repeat (ITEMS_PER_PHASE) begin
                op = ($urandom_range(0, 4) == 0) ? OP_LOAD : OP_TICK;
                case ($urandom_range(0, 9))
                    0:       phase = '0;
                    1:       phase = '1;
                    2:       phase = PHASE_BITS'($urandom_range(0, 3)) << (PHASE_BITS - 2);
                    default: phase = $urandom;
                endcase
                send_beat(op, phase);
            end
        end

        in_valid <= 1'b0;
        @(posedge i_clk);
        wait (outstanding == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        int gap;
        out_stall = 1'b0;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            if (hold_request) begin
                gap          = HOLD_CYCLES;
                hold_request = 1'b0;
            end else begin
                gap = receiver_quiet ? 0 : $urandom_range(0, MAX_GAP);
            end
            if (gap > 0) begin
                out_stall <= 1'b1;
                repeat (gap) @(posedge i_clk);
            end
            out_stall <= 1'b0;
            do @(posedge i_clk); while (!(out_valid && !out_stall));
        end
    end

    initial begin
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we || !i_rst_n)
            begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

`default_nettype wire
